FILE: design/dda_pkg.sv
`default_nettype none

package dda_pkg;

	localparam int unsigned CANVAS_SIZE = 64;

	localparam int unsigned COORD_W = 6;
	localparam int unsigned CFG_W   = 7;
	localparam int unsigned ACC_W   = COORD_W + 1;

	localparam logic [CFG_W-1:0] CANVAS_BOUND = CFG_W'(CANVAS_SIZE);
	localparam logic [CFG_W-1:0] CANVAS_RESET = CFG_W'(64);

	// configuration register indexes
	localparam logic REG_CANVAS_WIDTH  = 1'b0;
	localparam logic REG_CANVAS_HEIGHT = 1'b1;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CFG_W-1:0]   cfg_t;
	typedef logic [ACC_W-1:0]   acc_t;

endpackage

`default_nettype wire

FILE: design/dda_line_rasterizer.sv
`default_nettype none

// DDA line rasterizer.
// Input channel (in_valid / in_stall) carries one line command: start_x,
// start_y, end_x, end_y. Output channel (out_valid / out_stall) carries the
// points of the line, one item per point, from the start point to the end
// point; last_point marks the final one and visible says the point lies
// inside the configured canvas (bound is min(register, canvas size)).
// The config port (cfg_we, cfg_index, cfg_data) writes canvas_width (index 0)
// and canvas_height (index 1); write only while no line is in flight.
// A command with span n = max(|dx|, |dy|) yields n + 1 points. The command is
// captured into the line context registers, then a step unit produces one
// point per cycle while the output is not stalled; each point is registered
// in the output register. The step unit is one remainder accumulate, compare
// and subtract per axis; with the point counter it is the only arithmetic in
// the loop. in_stall stays high until the last point has been loaded into
// the output register.
// A stall on the output holds the current point and freezes the step unit.
// Reset drops any line in progress, empties the output register and sets
// both canvas registers to 64.

module dda_line_rasterizer
	import dda_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,

	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic [COORD_W-1:0] start_x,
	input  wire logic [COORD_W-1:0] start_y,
	input  wire logic [COORD_W-1:0] end_x,
	input  wire logic [COORD_W-1:0] end_y,

	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic [COORD_W-1:0] pixel_x,
	output      logic [COORD_W-1:0] pixel_y,
	output      logic               visible,
	output      logic               last_point
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic   state_q;
	cfg_t   width_q, height_q;

	// line context
	coord_t x0_q, y0_q, adx_q, ady_q, n_q, idx_q;
	logic   negx_q, negy_q;
	// quotient and remainder of i*|d| / n per axis
	coord_t qx_q, qy_q, rx_q, ry_q;

	logic   out_valid_q, last_q, vis_q;
	coord_t px_q, py_q;

	// command decode
	coord_t adx_in, ady_in;
	logic   negx_in, negy_in;

	// step unit
	acc_t   sumx, sumy;
	logic   carx, cary;
	coord_t cur_x, cur_y;
	cfg_t   wbound, hbound;
	logic   cur_last, cur_vis;
	logic   accept, load;

	assign negx_in = end_x < start_x;
	assign negy_in = end_y < start_y;
	assign adx_in  = negx_in ? (start_x - end_x) : (end_x - start_x);
	assign ady_in  = negy_in ? (start_y - end_y) : (end_y - start_y);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// load the next point when the output register is empty or being taken
	assign load     = (state_q == ST_RUN) && (!out_valid_q || !out_stall);

	// accumulate, compare and subtract: |d| <= n, so at most one carry a step
	assign sumx = {1'b0, rx_q} + {1'b0, adx_q};
	assign sumy = {1'b0, ry_q} + {1'b0, ady_q};
	assign carx = sumx >= {1'b0, n_q};
	assign cary = sumy >= {1'b0, n_q};

	assign cur_x    = negx_q ? (x0_q - qx_q) : (x0_q + qx_q);
	assign cur_y    = negy_q ? (y0_q - qy_q) : (y0_q + qy_q);
	assign wbound   = (width_q < CANVAS_BOUND) ? width_q : CANVAS_BOUND;
	assign hbound   = (height_q < CANVAS_BOUND) ? height_q : CANVAS_BOUND;
	assign cur_vis  = ({1'b0, cur_x} < wbound) && ({1'b0, cur_y} < hbound);
	assign cur_last = (idx_q == n_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CANVAS_RESET;
			height_q <= CANVAS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CANVAS_WIDTH:  width_q  <= cfg_data;
				REG_CANVAS_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_RUN;
				ST_RUN:  if (load && cur_last) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// line context and step unit
	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q   <= start_x;
			y0_q   <= start_y;
			adx_q  <= adx_in;
			ady_q  <= ady_in;
			negx_q <= negx_in;
			negy_q <= negy_in;
			n_q    <= (adx_in > ady_in) ? adx_in : ady_in;
			idx_q  <= '0;
			qx_q   <= '0;
			qy_q   <= '0;
			rx_q   <= '0;
			ry_q   <= '0;
		end else if (load && !cur_last) begin
			idx_q <= idx_q + COORD_W'(1);
			qx_q  <= qx_q + COORD_W'(carx);
			qy_q  <= qy_q + COORD_W'(cary);
			rx_q  <= carx ? COORD_W'(sumx - {1'b0, n_q}) : COORD_W'(sumx);
			ry_q  <= cary ? COORD_W'(sumy - {1'b0, n_q}) : COORD_W'(sumy);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q   <= cur_x;
			py_q   <= cur_y;
			vis_q  <= cur_vis;
			last_q <= cur_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign visible    = vis_q;
	assign last_point = last_q;

	// a command always enters the run state
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN))
		else $error("accepted command did not start a line");

	// remainder stays below the span while stepping
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && n_q != '0) |-> (rx_q < n_q && ry_q < n_q))
		else $error("step remainder out of range");

	// quotient never passes the axis span
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (qx_q <= adx_q && qy_q <= ady_q))
		else $error("step quotient past endpoint");

	// with no line running, nothing follows the last point once it is taken
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_point && state_q == ST_IDLE) |=> !out_valid)
		else $error("point emitted after last point");

	// step counter never passes the span
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (idx_q <= n_q))
		else $error("point counter past span");

endmodule

`default_nettype wire
